// File: hw/rtl/chm_pkg.sv
package chm_pkg;
    localparam int Buckets    = 256;
    localparam int Capacity   = 1024;
    localparam int IdxW       = 10;
    localparam int PtrW       = 11;
    localparam int BktW       = 8;
    localparam int CntW       = 9;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [PtrW-1:0] NIL = PtrW'(Capacity);

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

// File: hw/rtl/chm_mod.sv
// Shift-subtract remainder, one quotient bit per cycle.
module chm_mod
    import chm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [31:0]     i_num,
    input  logic [CntW-1:0] i_den,
    output t_div_ctl        o_ctl,
    output logic [BktW-1:0] o_rem
);
    logic [31:0]     r_num;
    logic [CntW:0]   r_rem;
    logic [5:0]      r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [CntW:0]   n_trial;
    logic [CntW:0]   n_rem;

    always_comb begin
        n_trial = {r_rem[CntW-1:0], r_num[31]};
        n_rem   = (n_trial >= {1'b0, i_den}) ? n_trial - {1'b0, i_den} : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_rem  <= '0;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[30:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_rem = r_rem[BktW-1:0];
endmodule

// File: hw/rtl/chained_hash_map_by_key.sv
// Channel | Direction | Handshake        | Payload
// request | in        | i_start, o_busy  | i_req_type, i_key, i_value, i_decl_*
// config  | in        | i_cfg_we         | i_cfg_data (bucket_count)
// result  | out       | o_strobe         | o_status, o_found_*
//
// A request other than a no-op computes the bucket remainder (one bit a cycle in the
// remainder unit), reads the bucket head, then reads and compares each chain entry
// visited; an insert whose key is not found then scans up to 1024 free-map entries
// for a free one. The result strobes from S_DONE after the walk or the scan.
// Reset clears the bucket-head valid bits at once; the free map is cleared by a
// sweep over all 1024 entries after reset, during which o_busy stays high.
// The receiver cannot stall: each result is shown for one cycle on o_strobe.
module chained_hash_map_by_key
    import chm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value,
    input  logic [15:0] i_decl_file,
    input  logic [19:0] i_decl_line,
    input  logic [11:0] i_decl_column,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_value,
    output logic [15:0] o_found_file,
    output logic [19:0] o_found_line,
    output logic [11:0] o_found_column
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MOD, S_HEAD, S_READ, S_CMP, S_SCAN, S_SCAN_CHK,
        S_INSERT, S_DELETE, S_DONE
    } t_state;

    // entry memory word: key, value, file, line, column, link
    typedef struct packed {
        logic [31:0]     key;
        logic [31:0]     value;
        logic [15:0]     file;
        logic [19:0]     line;
        logic [11:0]     column;
        logic [PtrW-1:0] link;
    } t_entry;

    t_state            r_state;
    logic [CntW-1:0]   r_bcount;
    logic [1:0]        r_req;
    logic [31:0]       r_key, r_value;
    logic [15:0]       r_file;
    logic [19:0]       r_line;
    logic [11:0]       r_column;
    logic [BktW-1:0]   r_bkt;
    logic [PtrW-1:0]   r_cur, r_prev, r_head;
    logic [PtrW-1:0]   r_steps;
    logic [IdxW:0]     r_scan;

    // memories
    t_entry            r_entries [Capacity];
    logic [PtrW-1:0]   r_heads   [Buckets];
    logic              r_hvalid  [Buckets];
    logic              r_used    [Capacity];
    t_entry            r_ent_q;
    logic [PtrW-1:0]   r_head_q;
    logic              r_used_q;

    // held copy of the previous entry, for relinking on delete
    t_entry            r_value_prev;

    logic              r_strobe;
    logic [1:0]        r_status;
    logic [31:0]       r_fvalue;
    logic [15:0]       r_ffile;
    logic [19:0]       r_fline;
    logic [11:0]       r_fcolumn;

    logic [CntW-1:0]   n_den;
    t_div_ctl          w_div;
    logic [BktW-1:0]   w_rem;
    logic              w_accept;
    logic [BktW-1:0]   w_haddr;

    assign w_accept = i_start && !o_busy;
    assign n_den = (r_bcount == '0) ? CntW'(1)
                 : (r_bcount > CntW'(Buckets)) ? CntW'(Buckets) : r_bcount;
    // read the head at the fresh remainder on the way out of S_MOD
    assign w_haddr = (r_state == S_MOD) ? w_rem : r_bkt;

    chm_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && i_req_type != REQ_NOP),
        .i_num   (i_key),
        .i_den   (n_den),
        .o_ctl   (w_div),
        .o_rem   (w_rem)
    );

    // entry memory: one write, one registered read at r_cur
    logic            n_ewe;
    logic [IdxW-1:0] n_eaddr;
    t_entry          n_edata;
    always_comb begin
        n_ewe   = 1'b0;
        n_eaddr = r_scan[IdxW-1:0];
        n_edata = r_ent_q;
        if (r_state == S_INSERT) begin
            n_ewe   = 1'b1;
            n_edata = '{key: r_key, value: r_value, file: r_file, line: r_line,
                        column: r_column, link: r_head};
        end else if (r_state == S_DELETE && r_prev != NIL) begin
            n_ewe   = 1'b1;
            n_eaddr = r_prev[IdxW-1:0];
            n_edata = r_value_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_ewe)
            r_entries[n_eaddr] <= n_edata;
        r_ent_q  <= r_entries[r_cur[IdxW-1:0]];
        r_head_q <= r_heads[w_haddr];
        r_used_q <= r_used[r_scan[IdxW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_bcount <= CntW'(Buckets);
            r_scan   <= '0;
            r_strobe <= 1'b0;
            for (int b = 0; b < Buckets; b++)
                r_hvalid[b] <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we)
                r_bcount <= i_cfg_data;
            unique case (r_state)
                S_CLEAR: begin
                    // sweep the free map
                    r_used[r_scan[IdxW-1:0]] <= 1'b0;
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == (IdxW+1)'(Capacity - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_req    <= i_req_type;
                        r_key    <= i_key;
                        r_value  <= i_value;
                        r_file   <= i_decl_file;
                        r_line   <= i_decl_line;
                        r_column <= i_decl_column;
                        r_status <= ST_MISS;
                        r_fvalue <= '0;
                        r_ffile  <= '0;
                        r_fline  <= '0;
                        r_fcolumn <= '0;
                        r_state  <= (i_req_type == REQ_NOP) ? S_DONE : S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_div.done) begin
                        r_bkt   <= w_rem;
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    // r_head_q holds the head of r_bkt this cycle
                    r_head  <= r_hvalid[r_bkt] ? r_head_q : NIL;
                    r_cur   <= r_hvalid[r_bkt] ? r_head_q : NIL;
                    r_prev  <= NIL;
                    r_steps <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_cur == NIL || r_steps == PtrW'(Capacity)) begin
                        r_cur   <= NIL;
                        r_scan  <= '0;
                        r_state <= (r_req == REQ_INSERT) ? S_SCAN : S_DONE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_ent_q.key == r_key) begin
                        if (r_req == REQ_INSERT) begin
                            r_state <= S_DONE;
                        end else begin
                            r_status <= ST_OK;
                            r_fvalue <= r_ent_q.value;
                            if (r_req == REQ_LOOKUP) begin
                                r_ffile   <= r_ent_q.file;
                                r_fline   <= r_ent_q.line;
                                r_fcolumn <= r_ent_q.column;
                                r_state   <= S_DONE;
                            end else begin
                                r_value_prev.link <= r_ent_q.link;
                                r_state <= S_DELETE;
                            end
                        end
                    end else begin
                        r_value_prev <= r_ent_q;
                        r_prev  <= r_cur;
                        r_cur   <= r_ent_q.link;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_SCAN: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (!r_used_q) begin
                        r_used[r_scan[IdxW-1:0]] <= 1'b1;
                        r_state <= S_INSERT;
                    end else if (r_scan == (IdxW+1)'(Capacity - 1)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_INSERT: begin
                    // entry written by the memory block; relink head
                    r_heads[r_bkt]  <= {1'b0, r_scan[IdxW-1:0]};
                    r_hvalid[r_bkt] <= 1'b1;
                    r_status <= ST_OK;
                    r_state  <= S_DONE;
                end
                S_DELETE: begin
                    if (r_prev == NIL) begin
                        r_heads[r_bkt]  <= r_value_prev.link;
                        r_hvalid[r_bkt] <= 1'b1;
                    end
                    r_used[r_cur[IdxW-1:0]] <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_found_value  = r_fvalue;
    assign o_found_file   = r_ffile;
    assign o_found_line   = r_fline;
    assign o_found_column = r_fcolumn;

    // a result follows only a finished request
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == S_DONE) else $error("stray strobe");
    // divider never starts while busy walking
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> r_state == S_MOD) else $error("divider out of step");
    // full status only on an insert request
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> r_req == REQ_INSERT)
        else $error("full on non-insert");
endmodule

// File: bench/tb.sv
module tb
    import chm_pkg::*;
;

    // Scoreboard: keeps its own copy of the map and the queue of expected results.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [15:0] file;
        logic [19:0] line;
        logic [11:0] column;
    } t_lookup_result;

    class map_scoreboard;
        int unsigned         modulus;
        logic [PtrW-1:0]     heads [Buckets];
        logic [31:0]         keys [Capacity];
        logic [31:0]         values [Capacity];
        logic [15:0]         files [Capacity];
        logic [19:0]         lines [Capacity];
        logic [11:0]         columns [Capacity];
        logic [PtrW-1:0]     links [Capacity];
        bit                  is_free [Capacity];
        t_lookup_result      pending [$];
        int                  errors;

        function void clear();
            modulus = 256;
            foreach (heads[i]) heads[i] = NIL;
            foreach (is_free[i]) begin
                is_free[i] = 1'b1;
                keys[i] = '0;
                links[i] = '0;
            end
            pending.delete();
        endfunction

        function void set_buckets(logic [8:0] count);
            modulus = count;
        endfunction

        function int unsigned bucket_of(logic [31:0] key);
            int unsigned m;
            m = modulus;
            if (m == 0) m = 1;
            if (m > Buckets) m = Buckets;
            return key % m;
        endfunction

        // Note an accepted request and compute its result.
        function void note_request(logic [1:0] req, logic [31:0] key, logic [31:0] value,
                                   logic [15:0] file, logic [19:0] line,
                                   logic [11:0] column);
            t_lookup_result r;
            int unsigned b, prev, cur, steps, i;
            r = '0;
            r.status = ST_MISS;
            b = bucket_of(key);
            prev = NIL;
            cur = heads[b];
            steps = 0;
            if (req != REQ_NOP) begin
                while (cur < Capacity && steps < Capacity) begin
                    if (keys[cur] == key) break;
                    prev = cur;
                    cur = links[cur];
                    steps++;
                end
                if (cur >= Capacity || steps >= Capacity) cur = NIL;
                if (req == REQ_INSERT) begin
                    if (cur == NIL) begin
                        for (i = 0; i < Capacity; i++)
                            if (is_free[i]) break;
                        if (i >= Capacity) begin
                            r.status = ST_FULL;
                        end else begin
                            is_free[i] = 1'b0;
                            keys[i] = key;
                            values[i] = value;
                            files[i] = file;
                            lines[i] = line;
                            columns[i] = column;
                            links[i] = heads[b];
                            heads[b] = PtrW'(i);
                            r.status = ST_OK;
                        end
                    end
                end else if (cur != NIL) begin
                    r.status = ST_OK;
                    r.value = values[cur];
                    if (req == REQ_LOOKUP) begin
                        r.file = files[cur];
                        r.line = lines[cur];
                        r.column = columns[cur];
                    end else begin
                        if (prev == NIL) heads[b] = links[cur];
                        else links[prev] = links[cur];
                        is_free[cur] = 1'b1;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_lookup_result got);
            t_lookup_result want;
            if (pending.size() == 0) begin
                report_mismatch("result with no request outstanding", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.value !== want.value)
                report_mismatch("found_value", got.value, want.value);
            if (got.file !== want.file)
                report_mismatch("found_file", got.file, want.file);
            if (got.line !== want.line)
                report_mismatch("found_line", got.line, want.line);
            if (got.column !== want.column)
                report_mismatch("found_column", got.column, want.column);
        endfunction

        function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_key = '0;
    logic [31:0] i_value = '0;
    logic [15:0] i_decl_file = '0;
    logic [19:0] i_decl_line = '0;
    logic [11:0] i_decl_column = '0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_data = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [31:0] o_found_value;
    logic [15:0] o_found_file;
    logic [19:0] o_found_line;
    logic [11:0] o_found_column;

    map_scoreboard sb;
    // Keys inserted so far, so that lookups and deletes mostly hit.
    logic [31:0]   key_pool [$];

    always #5 i_clk = ~i_clk;

    chained_hash_map_by_key dut (.*);

    // Check every strobed result at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result({o_status, o_found_value, o_found_file,
                             o_found_line, o_found_column});
    end

    // Issue one transaction: drive start with the request, then wait while the block is busy.
    task automatic send_request(logic [1:0] req, logic [31:0] key, logic [31:0] value,
                                logic [15:0] file, logic [19:0] line,
                                logic [11:0] column);
        i_start <= 1'b1;
        i_req_type <= req;
        i_key <= key;
        i_value <= value;
        i_decl_file <= file;
        i_decl_line <= line;
        i_decl_column <= column;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_request(req, key, value, file, line, column);
        if (req == REQ_INSERT) key_pool.push_back(key);
    endtask

    task automatic idle_cycles(int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Wait out every result, then let the block settle before a register write.
    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [8:0] count);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_buckets(count);
        @(posedge i_clk);
    endtask

    task automatic random_request(int miss_pct);
        logic [1:0]  req;
        logic [31:0] key;
        req = $urandom_range(0, 15) == 0 ? REQ_NOP : 2'($urandom_range(0, 2));
        if (key_pool.size() != 0 && $urandom_range(0, 99) >= miss_pct)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if ($urandom_range(0, 3) == 0)
            key = $urandom_range(0, 600);
        else
            key = $urandom();
        send_request(req, key, $urandom(), 16'($urandom()), 20'($urandom()),
                     12'($urandom()));
    endtask

    // Random phase: bursts of requests, separated at times by random idle gaps.
    task automatic random_phase(int count, int miss_pct);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && count > 0) begin
                random_request(miss_pct);
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
        end
    endtask

    initial begin
        #100_000_000;
        $display("chained_hash_map_by_key test failed");
        $finish;
    end

    initial begin
        sb = new();
        sb.clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every operation, request type three.
        send_request(REQ_INSERT, 32'h0, 32'h0, 16'h0, 20'h0, 12'h0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 12'hFFF);
        send_request(REQ_INSERT, 32'h100, 32'h1234_5678, 16'hA5A5, 20'h5A5A5, 12'hA5A);
        send_request(REQ_INSERT, 32'h0, 32'hDEAD_BEEF, 16'h1, 20'h1, 12'h1);
        send_request(REQ_LOOKUP, 32'h0, '0, '0, '0, '0);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_request(REQ_LOOKUP, 32'h100, '0, '0, '0, '0);
        send_request(REQ_LOOKUP, 32'h200, '0, '0, '0, '0);
        send_request(REQ_NOP, 32'h100, 32'h1, 16'h1, 20'h1, 12'h1);
        send_request(REQ_DELETE, 32'h0, '0, '0, '0, '0);
        send_request(REQ_DELETE, 32'h0, '0, '0, '0, '0);
        send_request(REQ_LOOKUP, 32'h100, '0, '0, '0, '0);
        send_request(REQ_DELETE, 32'h100, '0, '0, '0, '0);
        send_request(REQ_INSERT, 32'h7, 32'h77, 16'h7, 20'h7, 12'h7);

        // Bucket count of one puts everything in one chain; zero means one too.
        write_buckets(9'd1);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_request(REQ_INSERT, 32'h5, 32'h55, 16'h5, 20'h5, 12'h5);
        write_buckets(9'd0);
        send_request(REQ_LOOKUP, 32'h5, '0, '0, '0, '0);
        random_phase(150, 30);

        // Top of the register range saturates to the bucket limit.
        write_buckets(9'h1FF);
        random_phase(150, 30);

        write_buckets(9'd256);
        random_phase(100, 30);
        drain();

        write_buckets(9'd7);
        random_phase(100, 30);

        write_buckets(9'd256);
        random_phase(150, 10);

        drain();
        if (sb.errors == 0)
            $display("chained_hash_map_by_key test passed");
        else
            $display("chained_hash_map_by_key test failed");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/chm_pkg.sv
hw/rtl/chm_mod.sv
hw/rtl/chained_hash_map_by_key.sv
bench/tb.sv
